// ----- sv/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned KindW = 2;

  // Operation codes; the fourth code does nothing.
  typedef enum logic [KindW-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_ERASE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPLICE,
    ST_DONE
  } state_e;

  // One cache entry as it travels along the ring.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

endpackage

// ----- sv/lkvc_cell.sv -----
// One storage cell of the entry ring: holds an entry, takes its neighbor's on shift.
module lkvc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  lkvc_pkg::entry_t entry_i,
  output lkvc_pkg::entry_t entry_o
);

  logic                      valid_q;
  logic [lkvc_pkg::KeyW-1:0] key_q;
  logic [lkvc_pkg::ValW-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  // Key and value need no reset: an invalid cell is never matched.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= entry_i.key;
      value_q <= entry_i.value;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;

endmodule

// ----- sv/lru_key_value_cache_unit.sv -----
// A hit or any insert takes a search pass and a rewrite pass from accept to result valid;
//   a lookup miss, an erase miss or the unused code takes the search pass only.
// One item at a time: no new item is taken until the last result is loaded, which waits
//   while an earlier result is still held; the entry ring is one shift path, walked in full per pass.
// Reset: asynchronous, active low; the cache comes up empty, no clearing pass.
// Entries sit in recency order along the ring (cell 0 = most recent); holes allowed.
module lru_key_value_cache_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input item channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic        [lkvc_pkg::KindW-1:0] kind_i,
  input  logic signed [lkvc_pkg::KeyW-1:0]  key_i,
  input  logic signed [lkvc_pkg::ValW-1:0]  value_i,
  // result item channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic signed [lkvc_pkg::ValW-1:0]  read_value_o
);

  localparam int unsigned CntW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(CAPACITY - 1);

  // ---------------------------------------------------------------------------
  // Ring of cells. Every cell hands its entry to the lower neighbor while a
  // pass runs; cell 0 is the head, the splice logic feeds the top cell. After
  // a full pass of CAPACITY shifts the ring is back in its old alignment.
  // ---------------------------------------------------------------------------
  lkvc_pkg::entry_t cell_in  [CAPACITY];
  lkvc_pkg::entry_t cell_out [CAPACITY];
  lkvc_pkg::entry_t head;
  lkvc_pkg::entry_t tail;
  logic             shift;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == CAPACITY - 1) begin : g_top
      assign cell_in[gi] = tail;
    end else begin : g_mid
      assign cell_in[gi] = cell_out[gi+1];
    end
    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in[gi]),
      .entry_o (cell_out[gi])
    );
  end

  assign head = cell_out[0];

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  lkvc_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             found_q, found_d;     // search pass saw the key
  logic [CntW-1:0]  slot_q, slot_d;       // ring position of the match
  logic             direct_q, direct_d;   // splice no longer delayed by one
  logic             out_valid_q, out_valid_d;

  // payload registers
  logic [lkvc_pkg::KindW-1:0] kind_q, kind_d;
  logic [lkvc_pkg::KeyW-1:0]  key_q, key_d;
  logic [lkvc_pkg::ValW-1:0]  value_q, value_d;
  logic [lkvc_pkg::ValW-1:0]  found_val_q, found_val_d;
  lkvc_pkg::entry_t           carry_q, carry_d;
  logic                       hit_q, hit_d;
  logic [lkvc_pkg::ValW-1:0]  rv_q, rv_d;

  lkvc_pkg::entry_t hole;
  logic             key_eq;
  logic             at_match;
  logic             is_lookup;
  logic             is_insert;
  logic             is_erase;
  logic             need_splice;

  assign hole      = '{valid: 1'b0, key: '0, value: '0};
  assign key_eq    = head.valid && (head.key == key_q);
  assign at_match  = found_q && (cnt_q == slot_q);
  assign is_lookup = (kind_q == lkvc_pkg::KIND_LOOKUP);
  assign is_insert = (kind_q == lkvc_pkg::KIND_INSERT);
  assign is_erase  = (kind_q == lkvc_pkg::KIND_ERASE);
  assign shift     = (state_q == lkvc_pkg::ST_SEARCH) || (state_q == lkvc_pkg::ST_SPLICE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkvc_pkg::ST_IDLE;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      slot_q      <= '0;
      direct_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      slot_q      <= slot_d;
      direct_q    <= direct_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    value_q     <= value_d;
    found_val_q <= found_val_d;
    carry_q     <= carry_d;
    hit_q       <= hit_d;
    rv_q        <= rv_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    slot_d      = slot_q;
    direct_d    = direct_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    key_d       = key_q;
    value_d     = value_q;
    found_val_d = found_val_q;
    carry_d     = carry_q;
    hit_d       = hit_q;
    rv_d        = rv_q;
    tail        = head;
    need_splice = 1'b0;
    in_stall_o  = 1'b1;

    // result leaves when the far side takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          kind_d  = kind_i;
          key_d   = key_i;
          value_d = value_i;
          found_d = 1'b0;
          cnt_d   = '0;
          state_d = lkvc_pkg::ST_SEARCH;
        end
      end

      // Pass 1: rotate unchanged, compare the head key each cycle.
      lkvc_pkg::ST_SEARCH: begin
        tail = head;
        if (key_eq && !found_q) begin
          found_d     = 1'b1;
          slot_d      = cnt_q;
          found_val_d = head.value;
        end
        if (cnt_q == LastIdx) begin
          cnt_d       = '0;
          need_splice = is_insert || ((is_lookup || is_erase) && found_d);
          // Touch and insert put a new front entry; erase only punches a hole.
          direct_d    = is_erase;
          carry_d     = '{valid: 1'b1, key: key_q,
                          value: found_d ? found_val_d : value_q};
          state_d     = need_splice ? lkvc_pkg::ST_SPLICE : lkvc_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Pass 2: stream rewrite. Delayed mode emits the carry and keeps the head;
      // the first hole or the matched entry is swallowed and the stream goes
      // direct. A full cache with no match drops the last (least recent) entry.
      lkvc_pkg::ST_SPLICE: begin
        if (!direct_q) begin
          tail = carry_q;
          if (!head.valid || at_match) begin
            direct_d = 1'b1;
          end else begin
            carry_d = head;
          end
        end else begin
          tail = at_match ? hole : head;
        end
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = lkvc_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      lkvc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          hit_d       = found_q && (is_lookup || is_erase);
          rv_d        = (found_q && is_lookup) ? found_val_q : '0;
          state_d     = lkvc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rv_q;

`ifndef SYNTHESIS
  // The rewrite pass only ever follows a complete search pass.
  a_splice_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::ST_SPLICE) && ($past(state_q) == lkvc_pkg::ST_SEARCH)
    |-> ($past(cnt_q) == LastIdx))
    else $error("splice started before the search pass finished");

  // A fresh search starts with no match recorded.
  a_search_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::ST_SEARCH) && (cnt_q == '0) |-> !found_q)
    else $error("stale match at start of search");

  // Once the splice has gone direct it stays direct to the end of the pass.
  a_direct_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::ST_SPLICE) && direct_q && (cnt_q != LastIdx) |=> direct_q)
    else $error("splice fell back to delayed mode");

  // A recorded match position lies in the part of the ring already searched.
  a_slot_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::ST_SEARCH) && found_q |-> (slot_q < cnt_q))
    else $error("match slot ahead of search position");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the LRU key-value cache unit.
module tb_top;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned LATENCY_MAX = 2 * SLOTS + 2;
  localparam int unsigned POOL_SIZE   = 32;
  // Fourth operation code: no state change, answers a miss.
  localparam logic [lkvc_pkg::KindW-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic                      hit;
    logic [lkvc_pkg::ValW-1:0] read_value;
  } cache_answer_t;

  logic                               clk_i        = 1'b0;
  logic                               rst_ni       = 1'b0;
  logic                               in_valid_i   = 1'b0;
  logic                               in_stall_o;
  logic        [lkvc_pkg::KindW-1:0]  kind_i       = lkvc_pkg::KIND_LOOKUP;
  logic signed [lkvc_pkg::KeyW-1:0]   key_i        = '0;
  logic signed [lkvc_pkg::ValW-1:0]   value_i      = '0;
  logic                               out_valid_o;
  logic                               out_stall_i  = 1'b0;
  logic                               hit_o;
  logic signed [lkvc_pkg::ValW-1:0]   read_value_o;

  // Shadow copy of the cache: keys, values, occupancy and recency rank
  // (rank 0 = most recent). Ranks of empty slots carry no meaning.
  logic [lkvc_pkg::KeyW-1:0] slot_key   [SLOTS];
  logic [lkvc_pkg::ValW-1:0] slot_value [SLOTS];
  bit                        slot_live  [SLOTS];
  int unsigned               slot_rank  [SLOTS];

  // Answers predicted for accepted items, oldest first.
  cache_answer_t pending_answers[$];

  logic [lkvc_pkg::KeyW-1:0] key_pool[POOL_SIZE];
  int unsigned     error_count    = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_req       = 0;
  int unsigned     hold_left      = 0;

  lru_key_value_cache_unit #(
    .CAPACITY(SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow cache
  // ---------------------------------------------------------------------------

  // Promote slot s to most recent; everything that was newer ages by one.
  function automatic void make_newest(input int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // Free slot s and close the hole it leaves in the rank order.
  function automatic void retire_slot(input int s);
    int unsigned r;
    r = slot_rank[s];
    slot_live[s] = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_rank[i] > r) slot_rank[i]--;
    end
  endfunction

  // Applies one operation to the shadow cache and returns the answer it gives.
  function automatic cache_answer_t apply_cache_op(
    input logic [lkvc_pkg::KindW-1:0] kind,
    input logic [lkvc_pkg::KeyW-1:0]  key,
    input logic [lkvc_pkg::ValW-1:0]  value
  );
    cache_answer_t ans;
    int            found;
    int            victim;
    int            free_slot;
    int unsigned   live_n;
    ans       = '0;
    found     = -1;
    victim    = -1;
    free_slot = -1;
    live_n    = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) live_n++;
      if (slot_live[i] && slot_key[i] == key && found < 0) found = i;
    end
    case (kind)
      lkvc_pkg::KIND_LOOKUP: begin
        if (found >= 0) begin
          ans.hit        = 1'b1;
          ans.read_value = slot_value[found];
          make_newest(found);
        end
      end
      lkvc_pkg::KIND_INSERT: begin
        // A key already present keeps its old value and only gets promoted.
        if (found >= 0) begin
          make_newest(found);
        end else begin
          if (live_n >= SLOTS) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_live[i] && slot_rank[i] == SLOTS - 1) victim = i;
            end
            if (victim >= 0) retire_slot(victim);
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) slot_rank[i]++;
            else if (free_slot < 0) free_slot = i;
          end
          if (free_slot >= 0) begin
            slot_key[free_slot]   = key;
            slot_value[free_slot] = value;
            slot_live[free_slot]  = 1'b1;
            slot_rank[free_slot]  = 0;
          end
        end
      end
      lkvc_pkg::KIND_ERASE: begin
        if (found >= 0) begin
          ans.hit = 1'b1;
          retire_slot(found);
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall generation and answer checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what,
                                 input logic [lkvc_pkg::ValW-1:0] want,
                                 input logic [lkvc_pkg::ValW-1:0] got);
    error_count++;
    $display("MISMATCH %s: expected %h, got %h", what, want, got);
  endtask

  // A hold-off request pins the stall high until its count runs out; otherwise
  // the stall is random at the current rate.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cache_answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result item", '0, read_value_o);
      end else begin
        want = pending_answers.pop_front();
        if (hit_o !== want.hit)
          report_mismatch("hit", {{(lkvc_pkg::ValW-1){1'b0}}, want.hit},
                          {{(lkvc_pkg::ValW-1){1'b0}}, hit_o});
        if (read_value_o !== want.read_value)
          report_mismatch("read_value", want.read_value, read_value_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one item, with random idle cycles ahead of it, and records its
  // predicted answer once accepted. Returns at the accepting edge with valid
  // still high, so a following item can go out back to back.
  task automatic send_item(input logic [lkvc_pkg::KindW-1:0] kind,
                           input logic [lkvc_pkg::KeyW-1:0]  key,
                           input logic [lkvc_pkg::ValW-1:0]  value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_answers.push_back(apply_cache_op(kind, key, value));
  endtask

  // Drops valid and waits until every predicted answer has been checked.
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty-cache misses, extreme keys and values, duplicate insert keeping the
  // old value, erase hit then erase miss, unused code on a present key.
  task automatic test_basics();
    send_item(lkvc_pkg::KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::KIND_ERASE,  32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lkvc_pkg::KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(lkvc_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(lkvc_pkg::KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lkvc_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_item(lkvc_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::KIND_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_item(lkvc_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(lkvc_pkg::KIND_ERASE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::KIND_ERASE,  32'hFFFF_FFFF, 32'h0000_0000);
    send_item(KIND_UNUSED,           32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // Fill the free slots, then one more new key pushes out the oldest entry;
  // the looked-up key below is the least recent one left by test_basics.
  task automatic test_eviction();
    for (int i = 0; i < 14; i++) begin
      send_item(lkvc_pkg::KIND_INSERT, 32'h0000_0100 + i, $urandom);
    end
    send_item(lkvc_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Mostly operations on a pool of keys so hits, duplicate inserts and
  // evictions are common; a tenth use fully random keys.
  task automatic test_random_ops(input int n, input int unsigned send_pct,
                                 input int unsigned recv_pct, input int unsigned pool_n);
    int unsigned                pick;
    logic [lkvc_pkg::KindW-1:0] kind;
    logic [lkvc_pkg::KeyW-1:0]  key;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40)      kind = lkvc_pkg::KIND_LOOKUP;
      else if (pick < 75) kind = lkvc_pkg::KIND_INSERT;
      else if (pick < 94) kind = lkvc_pkg::KIND_ERASE;
      else                kind = KIND_UNUSED;
      if ($urandom_range(9) == 0) key = $urandom;
      else                        key = key_pool[$urandom_range(pool_n - 1)];
      send_item(kind, key, $urandom);
    end
  endtask

  // Result side frozen for a long stretch while items keep coming, so the
  // unit backs up and stalls its input.
  task automatic test_receiver_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 300;
    for (int i = 0; i < 12; i++) begin
      send_item(($urandom_range(1) != 0) ? lkvc_pkg::KIND_INSERT : lkvc_pkg::KIND_LOOKUP,
                key_pool[$urandom_range(7)], $urandom);
    end
  endtask

  // Sender goes quiet until the unit has answered everything, then resumes.
  task automatic test_drain_pause();
    for (int i = 0; i < 8; i++) send_item(lkvc_pkg::KIND_INSERT, key_pool[i], $urandom);
    drain_answers();
    for (int i = 0; i < 8; i++) send_item(lkvc_pkg::KIND_LOOKUP, key_pool[i], $urandom);
    drain_answers();
    for (int i = 0; i < 4; i++) send_item(lkvc_pkg::KIND_ERASE, key_pool[i], $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_live[i]  = 1'b0;
      slot_rank[i]  = 0;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Sender idles rarely, receiver stalls most cycles for the first phase.
    send_idle_pct  = 8;
    recv_stall_pct = 81;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basics();
    test_eviction();
    test_random_ops(230, 8, 81, 24);
    test_random_ops(230, 81, 8, 12);
    test_random_ops(200, 0, 0, 20);
    test_receiver_hold();
    test_drain_pause();

    drain_answers();
    // Room for any stray result item the unit might still emit.
    repeat (LATENCY_MAX + 8) @(posedge clk_i);
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("lru_key_value_cache_unit verification clean");
    end else begin
      $display("lru_key_value_cache_unit verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("lru_key_value_cache_unit verification failed");
    $finish;
  end

endmodule
